@@ hdl/mavg_pkg.sv @@
// Shared constants, types and codes for the moving average filter.
`default_nettype none
package mavg_pkg;
	localparam int MAX_WINDOW   = 256;
	localparam int SAMPLE_WIDTH = 24;
	localparam int PTR_W        = $clog2(MAX_WINDOW);
	localparam int LEN_W        = $clog2(MAX_WINDOW + 1);
	localparam int SUM_W        = SAMPLE_WIDTH + PTR_W;
	localparam int CNT_W        = $clog2(SUM_W);
	localparam int CFG_W        = (SAMPLE_WIDTH > LEN_W) ? SAMPLE_WIDTH : LEN_W;
	localparam int IDX_W        = 2;
	localparam int MODE_W       = 2;

	typedef enum logic [IDX_W-1:0] {
		REG_WINDOW_LENGTH = 2'd0,
		REG_SEED_MODE     = 2'd1,
		REG_SEED_VALUE    = 2'd2
	} mavg_reg_t;

	typedef enum logic [MODE_W-1:0] {
		SEED_ZERO  = 2'd0,
		SEED_FIRST = 2'd1,
		SEED_VALUE = 2'd2
	} mavg_seed_t;

	localparam logic [LEN_W-1:0]  RST_WINDOW_LENGTH = LEN_W'(8);
	localparam logic [MODE_W-1:0] RST_SEED_MODE     = SEED_FIRST;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_UPDATE,
		ST_DINIT,
		ST_DIV,
		ST_FIN
	} mavg_state_t;

	typedef struct packed {
		logic accept;
		logic load;
		logic update;
		logic div_init;
		logic div_step;
		logic out_load;
	} mavg_cmd_t;

	typedef struct packed {
		logic div_done;
	} mavg_stat_t;
endpackage
`default_nettype wire

@@ hdl/moving_average_filter.sv @@
// Top level of the boxcar moving average filter.
// Input channel: sample with in_valid/in_stall; a transaction completes when
// in_valid is high and in_stall low. Output channel: average with
// out_valid/out_stall, one result per input sample.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; index 0 is
// window_length, 1 seed_mode, 2 seed_value. cfg_ready is always high; write
// only while the block is idle. Writes to index 0 to 2 re-seed the filter.
// After acceptance each sample passes through seeding with the window store
// read, the running sum update, divider setup, the one-bit-per-cycle
// restoring divider by the window length and the load of the output
// register. A new sample is taken in the cycle after the result is loaded;
// the block takes no new sample while one is still being processed.
// If the receiver stalls, the result holds in the output register; the next
// sample is still accepted and processed, then waits in its final state.
// Reset clears the controller, pointers, sum and seed state and restores the
// register defaults (window 8, seed from first sample, seed value 0).
`default_nettype none
module moving_average_filter import mavg_pkg::*; (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic signed [SAMPLE_WIDTH-1:0] sample,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic signed [SAMPLE_WIDTH-1:0]      average,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [IDX_W-1:0]               cfg_index,
	input  wire logic [CFG_W-1:0]               cfg_data
);
	mavg_cmd_t  cmd;
	mavg_stat_t stat;

	assign cfg_ready = 1'b1;

	mavg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	mavg_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_valid && cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.sample   (sample),
		.cmd      (cmd),
		.stat     (stat),
		.average  (average)
	);
endmodule
`default_nettype wire

@@ hdl/mavg_ram.sv @@
// Generic single write port RAM with registered read.
`default_nettype none
module mavg_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end
endmodule
`default_nettype wire

@@ hdl/mavg_ctrl.sv @@
// Controller state machine sequencing one sample through the datapath.
`default_nettype none
module mavg_ctrl import mavg_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	output logic            out_valid,
	input  wire logic       out_stall,
	input  wire mavg_stat_t stat,
	output mavg_cmd_t       cmd
);
	mavg_state_t state_q, state_d;
	logic        out_valid_q;
	logic        out_free;

	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = ST_LOAD;
				end
			end
			ST_LOAD: begin
				cmd.load = 1'b1;
				state_d  = ST_UPDATE;
			end
			ST_UPDATE: begin
				cmd.update = 1'b1;
				state_d    = ST_DINIT;
			end
			ST_DINIT: begin
				cmd.div_init = 1'b1;
				state_d      = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (stat.div_done) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end
endmodule
`default_nettype wire

@@ hdl/mavg_dp.sv @@
// Datapath: configuration, window store, running sum and restoring divider.
`default_nettype none
module mavg_dp import mavg_pkg::*; (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [IDX_W-1:0]               cfg_index,
	input  wire logic [CFG_W-1:0]               cfg_data,
	input  wire logic signed [SAMPLE_WIDTH-1:0] sample,
	input  wire mavg_cmd_t                      cmd,
	output mavg_stat_t                          stat,
	output logic signed [SAMPLE_WIDTH-1:0]      average
);
	logic [LEN_W-1:0]               window_length_q;
	logic [MODE_W-1:0]              seed_mode_q;
	logic signed [SAMPLE_WIDTH-1:0] seed_value_q;
	logic                           seeded_q;
	logic signed [SAMPLE_WIDTH-1:0] sample_q;
	logic signed [SAMPLE_WIDTH-1:0] seed_q;
	logic signed [SUM_W-1:0]        sum_q;
	logic [PTR_W-1:0]               wp_q;
	logic [LEN_W-1:0]               fill_q;
	logic [SUM_W-1:0]               dq_q;
	logic [LEN_W-1:0]               rem_q;
	logic                           neg_q;
	logic [CNT_W-1:0]               cnt_q;

	logic [LEN_W-1:0]               len;
	logic signed [SAMPLE_WIDTH-1:0] seed_sel;
	logic signed [SUM_W-1:0]        seed_sum;
	logic [PTR_W:0]                 rd_idx;
	logic [PTR_W-1:0]               wp_next;
	logic [SAMPLE_WIDTH-1:0]        rd_data;
	logic signed [SAMPLE_WIDTH-1:0] leaving;
	logic                           filling;
	logic [LEN_W:0]                 trial;
	logic [LEN_W:0]                 shifted;
	logic [SUM_W-1:0]               quot;

	always_comb begin
		if (window_length_q == '0) begin
			len = LEN_W'(1);
		end else if (window_length_q > LEN_W'(MAX_WINDOW)) begin
			len = LEN_W'(MAX_WINDOW);
		end else begin
			len = window_length_q;
		end
	end

	always_comb begin
		case (seed_mode_q)
			SEED_FIRST: seed_sel = sample_q;
			SEED_VALUE: seed_sel = seed_value_q;
			default:    seed_sel = '0;
		endcase
	end

	assign seed_sum = SUM_W'(seed_sel) * SUM_W'($signed({1'b0, len}));
	assign filling  = fill_q < len;
	assign leaving  = filling ? seed_q : $signed(rd_data);

	always_comb begin
		if ({1'b0, wp_q} >= (PTR_W + 1)'(len)) begin
			rd_idx = {1'b0, wp_q} - (PTR_W + 1)'(len);
		end else begin
			rd_idx = {1'b0, wp_q} + (PTR_W + 1)'(MAX_WINDOW) - (PTR_W + 1)'(len);
		end
		if (wp_q == PTR_W'(MAX_WINDOW - 1)) begin
			wp_next = '0;
		end else begin
			wp_next = wp_q + PTR_W'(1);
		end
	end

	mavg_ram #(
		.WIDTH(SAMPLE_WIDTH),
		.DEPTH(MAX_WINDOW)
	) u_window (
		.clk    (clk),
		.wr_en  (cmd.update),
		.wr_addr(wp_q),
		.wr_data(sample_q),
		.rd_en  (cmd.load),
		.rd_addr(rd_idx[PTR_W-1:0]),
		.rd_data(rd_data)
	);

	assign shifted       = {rem_q, dq_q[SUM_W-1]};
	assign trial         = shifted - {1'b0, len};
	assign stat.div_done = cnt_q == CNT_W'(SUM_W - 1);
	assign quot          = neg_q ? (~dq_q + SUM_W'(1)) : dq_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_length_q <= RST_WINDOW_LENGTH;
			seed_mode_q     <= RST_SEED_MODE;
			seed_value_q    <= '0;
			seeded_q        <= 1'b0;
			seed_q          <= '0;
			sum_q           <= '0;
			wp_q            <= '0;
			fill_q          <= '0;
			cnt_q           <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_WINDOW_LENGTH: begin
						window_length_q <= cfg_data[LEN_W-1:0];
						seeded_q        <= 1'b0;
					end
					REG_SEED_MODE: begin
						seed_mode_q <= cfg_data[MODE_W-1:0];
						seeded_q    <= 1'b0;
					end
					REG_SEED_VALUE: begin
						seed_value_q <= $signed(cfg_data[SAMPLE_WIDTH-1:0]);
						seeded_q     <= 1'b0;
					end
					default: begin
					end
				endcase
			end
			if (cmd.load && !seeded_q) begin
				seed_q   <= seed_sel;
				sum_q    <= seed_sum;
				fill_q   <= '0;
				wp_q     <= '0;
				seeded_q <= 1'b1;
			end
			if (cmd.update) begin
				sum_q <= sum_q + SUM_W'(sample_q) - SUM_W'(leaving);
				wp_q  <= wp_next;
				if (filling) begin
					fill_q <= fill_q + LEN_W'(1);
				end
			end
			if (cmd.div_init) begin
				cnt_q <= '0;
			end else if (cmd.div_step) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			sample_q <= sample;
		end
		if (cmd.div_init) begin
			neg_q <= sum_q[SUM_W-1];
			dq_q  <= sum_q[SUM_W-1] ? (~sum_q + SUM_W'(1)) : sum_q;
			rem_q <= '0;
		end else if (cmd.div_step) begin
			if (!trial[LEN_W]) begin
				rem_q <= trial[LEN_W-1:0];
				dq_q  <= {dq_q[SUM_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[LEN_W-1:0];
				dq_q  <= {dq_q[SUM_W-2:0], 1'b0};
			end
		end
		if (cmd.out_load) begin
			average <= $signed(quot[SAMPLE_WIDTH-1:0]);
		end
	end
endmodule
`default_nettype wire

@@ test/tb_moving_average_filter.sv @@
// Self-checking testbench for the boxcar moving average filter.
`default_nettype none

typedef logic signed [mavg_pkg::SAMPLE_WIDTH-1:0] sample_t;

class average_tracker;
	sample_t                         window [mavg_pkg::MAX_WINDOW];
	logic [mavg_pkg::PTR_W-1:0]      wr_ptr;
	int                              filled;
	longint                          total;
	sample_t                         seed;
	bit                              seeded;
	logic [mavg_pkg::LEN_W-1:0]      win_len;
	logic [mavg_pkg::MODE_W-1:0]     mode;
	sample_t                         seed_val;
	sample_t                         expected_averages [$];
	int                              mismatches;

	function new();
		wr_ptr     = '0;
		filled     = 0;
		total      = 0;
		seed       = '0;
		seeded     = 0;
		win_len    = mavg_pkg::RST_WINDOW_LENGTH;
		mode       = mavg_pkg::RST_SEED_MODE;
		seed_val   = '0;
		mismatches = 0;
	endfunction

	function int span();
		if (win_len == 0)
			return 1;
		if (win_len > mavg_pkg::MAX_WINDOW)
			return mavg_pkg::MAX_WINDOW;
		return int'(win_len);
	endfunction

	function void write_register(logic [mavg_pkg::IDX_W-1:0] idx,
			logic [mavg_pkg::CFG_W-1:0] data);
		case (idx)
			mavg_pkg::REG_WINDOW_LENGTH: begin
				win_len = data[mavg_pkg::LEN_W-1:0];
				seeded  = 0;
			end
			mavg_pkg::REG_SEED_MODE: begin
				mode   = data[mavg_pkg::MODE_W-1:0];
				seeded = 0;
			end
			mavg_pkg::REG_SEED_VALUE: begin
				seed_val = data[mavg_pkg::SAMPLE_WIDTH-1:0];
				seeded   = 0;
			end
			default: ;
		endcase
	endfunction

	function void take_sample(sample_t s);
		int                         len;
		sample_t                    leaving;
		logic [mavg_pkg::PTR_W-1:0] idx;
		longint                     q;
		len = span();
		if (!seeded) begin
			case (mode)
				mavg_pkg::SEED_FIRST: seed = s;
				mavg_pkg::SEED_VALUE: seed = seed_val;
				default:              seed = '0;
			endcase
			total  = longint'(seed) * longint'(len);
			filled = 0;
			wr_ptr = '0;
			seeded = 1;
		end
		if (filled < len) begin
			leaving = seed;
		end else begin
			idx     = wr_ptr - mavg_pkg::PTR_W'(len);
			leaving = window[idx];
		end
		total = total + longint'(s) - longint'(leaving);
		window[wr_ptr] = s;
		wr_ptr = wr_ptr + mavg_pkg::PTR_W'(1);
		if (filled < len)
			filled++;
		q = total / longint'(len);
		expected_averages.insert(expected_averages.size(), q[mavg_pkg::SAMPLE_WIDTH-1:0]);
	endfunction

	function void check_average(sample_t got);
		sample_t want;
		if (expected_averages.size() == 0) begin
			$display("%0t: average %0d arrived with no sample outstanding", $time, got);
			mismatches++;
		end else begin
			want = expected_averages.pop_front();
			if (got !== want) begin
				$display("%0t: average mismatch, expected %0d actual %0d", $time, want, got);
				mismatches++;
			end
		end
	endfunction

	function int pending();
		return expected_averages.size();
	endfunction
endclass

module tb_moving_average_filter import mavg_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
	localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
	localparam int RANDOM_ITEMS = 1350;
	localparam int CYCLE_LIMIT  = 1000000;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   in_valid = 1'b0;
	logic                   in_stall;
	sample_t                sample = '0;
	logic                   out_valid;
	logic                   out_stall = 1'b0;
	sample_t                average;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [IDX_W-1:0]       cfg_index = '0;
	logic [CFG_W-1:0]       cfg_data = '0;

	average_tracker tracker = new();
	int tx_pct = 0;
	int rx_pct = 0;
	int cycles = 0;

	moving_average_filter DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.sample    (sample),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.average   (average),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	always @(negedge clk) begin
		if (arst_n)
			out_stall <= ($urandom_range(0, 99) < rx_pct);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			tracker.check_average(average);
	end

	// in_valid is left high on return; flush lowers it
	task automatic put_sample(sample_t v);
		while ($urandom_range(0, 99) < tx_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		sample   <= v;
		do @(posedge clk); while (in_stall);
		tracker.take_sample(v);
		@(negedge clk);
	endtask

	task automatic flush();
		in_valid <= 1'b0;
		while (tracker.pending() != 0) @(negedge clk);
		repeat (40) @(negedge clk);
	endtask

	task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		tracker.write_register(idx, data);
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	function automatic sample_t rand_sample();
		logic [31:0] r;
		r = $urandom();
		case ($urandom_range(0, 9))
			0:       return SAMPLE_MAX;
			1:       return SAMPLE_MIN;
			2:       return sample_t'($signed($urandom_range(0, 64)) - 32);
			default: return r[SAMPLE_WIDTH-1:0];
		endcase
	endfunction

	function automatic logic [CFG_W-1:0] rand_seed_value();
		logic [31:0] r;
		r = $urandom();
		case ($urandom_range(0, 5))
			0:       return CFG_W'(SAMPLE_MAX);
			1:       return CFG_W'(SAMPLE_MIN);
			default: return r[CFG_W-1:0];
		endcase
	endfunction

	function automatic logic [CFG_W-1:0] rand_window();
		case ($urandom_range(0, 24))
			0:          return '0;
			1:          return CFG_W'($urandom_range(257, 511));
			2:          return CFG_W'(MAX_WINDOW);
			3:          return CFG_W'($urandom_range(100, 255));
			4, 5, 6, 7: return CFG_W'($urandom_range(17, 64));
			default:    return CFG_W'($urandom_range(1, 16));
		endcase
	endfunction

	initial begin
		int  done_items;
		int  n;
		bit  wrote;
		done_items = 0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset defaults: window of eight, seeded from the first sample
		put_sample(SAMPLE_MAX);
		put_sample(SAMPLE_MAX);
		put_sample(SAMPLE_MIN);
		put_sample(sample_t'(-1));
		put_sample(sample_t'(0));
		flush();
		write_reg(REG_WINDOW_LENGTH, CFG_W'(1));
		put_sample(SAMPLE_MIN);
		put_sample(SAMPLE_MAX);
		flush();
		write_reg(REG_WINDOW_LENGTH, CFG_W'(0));
		put_sample(sample_t'(5));
		put_sample(sample_t'(-5));
		flush();
		// truncation toward zero with negative sums
		write_reg(REG_WINDOW_LENGTH, CFG_W'(3));
		write_reg(REG_SEED_MODE, CFG_W'(SEED_ZERO));
		put_sample(sample_t'(-1));
		put_sample(sample_t'(-1));
		put_sample(sample_t'(2));
		flush();
		write_reg(REG_SEED_VALUE, CFG_W'(-77));
		write_reg(REG_WINDOW_LENGTH, CFG_W'(300));
		write_reg(REG_SEED_MODE, CFG_W'(3));
		put_sample(sample_t'(-4));
		put_sample(SAMPLE_MAX);
		flush();
		write_reg(REG_SEED_MODE, CFG_W'(SEED_VALUE));
		write_reg(REG_SEED_VALUE, CFG_W'(SAMPLE_MIN));
		write_reg(REG_WINDOW_LENGTH, CFG_W'(MAX_WINDOW));
		put_sample(SAMPLE_MIN);
		put_sample(SAMPLE_MAX);
		flush();
		write_reg(REG_SEED_VALUE, CFG_W'(SAMPLE_MAX));
		write_reg(REG_WINDOW_LENGTH, CFG_W'(2));
		put_sample(sample_t'(1));
		put_sample(sample_t'(1));
		put_sample(sample_t'(1));
		flush();
		// unmapped index: no re-seed, window carries on
		write_reg(REG_UNUSED, '1);
		put_sample(sample_t'(1));
		flush();

		while (done_items < RANDOM_ITEMS) begin
			if (done_items < RANDOM_ITEMS / 3) begin
				tx_pct = 25;
				rx_pct = 52;
			end else if (done_items < 2 * RANDOM_ITEMS / 3) begin
				tx_pct = 52;
				rx_pct = 25;
			end else begin
				tx_pct = 0;
				rx_pct = 0;
			end
			wrote = 0;
			if ($urandom_range(0, 1)) begin
				write_reg(REG_WINDOW_LENGTH, rand_window());
				wrote = 1;
			end
			if ($urandom_range(0, 1)) begin
				write_reg(REG_SEED_MODE, CFG_W'($urandom_range(0, 3)));
				wrote = 1;
			end
			if ($urandom_range(0, 1)) begin
				write_reg(REG_SEED_VALUE, rand_seed_value());
				wrote = 1;
			end
			if (!wrote && $urandom_range(0, 1))
				write_reg(REG_UNUSED, CFG_W'($urandom()));
			n = tracker.span() + $urandom_range(1, 40);
			if (n > RANDOM_ITEMS - done_items)
				n = RANDOM_ITEMS - done_items;
			repeat (n) begin
				put_sample(rand_sample());
				done_items++;
			end
			flush();
		end

		rx_pct = 0;
		flush();
		if (tracker.mismatches == 0 && tracker.pending() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end
endmodule
`default_nettype wire
